### sv/rtpsr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RTP sequence rewriter.
// No dependencies; used by rtp_sequence_rewriter_on_frame_drop_top.
package rtpsr_pkg;

    localparam int SEQ_W      = 16;
    localparam int FRAME_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DROP_WHEN_UNSURE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_THRESHOLD   = 2'd1;

    localparam logic [SEQ_W-1:0] SKIP_THRESHOLD_RESET = 16'd3;
    localparam logic [SEQ_W-1:0] EDGE_REMOVE          = 16'd2;
    localparam logic [SEQ_W-1:0] NEXT_GAP_REMOVE      = 16'd3;

    typedef enum logic [1:0] {
        MARK_INTER = 2'd0,
        MARK_START = 2'd1,
        MARK_END   = 2'd2
    } t_mark;

endpackage

### sv/rtp_sequence_rewriter_on_frame_drop_top.sv
`timescale 1ns / 1ps
// A request accepted is held in the input register, and its result then in the output register.
// Throughput: one request per cycle while the output is not stalled; an input register and an output register
// let one request enter while a finished result waits to be taken.
// Reset (synchronous, active low) clears all frame state and the removed count
// and returns drop_when_unsure to 0 and the skip threshold to 3.
// Top level of the RTP sequence rewriter; depends on rtpsr_pkg.
module rtp_sequence_rewriter_on_frame_drop_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rtpsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtpsr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rtpsr_pkg::FRAME_W-1:0]     i_frame_number,
    input  logic [rtpsr_pkg::SEQ_W-1:0]       i_seq_number,
    input  logic                              i_start_of_frame,
    input  logic                              i_end_of_frame,
    input  logic                              i_drop_packet,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_seq_valid,
    output logic [rtpsr_pkg::SEQ_W-1:0]       o_new_seq_number
);

    localparam int SW = rtpsr_pkg::SEQ_W;
    localparam int FW = rtpsr_pkg::FRAME_W;

    logic                 r_drop_when_unsure;
    logic [SW-1:0]        r_skip_threshold;

    logic                 r_in_valid;
    logic [FW-1:0]        r_in_frame;
    logic [SW-1:0]        r_in_seq;
    logic                 r_in_sof;
    logic                 r_in_eof;
    logic                 r_in_drop;

    logic                 r_out_valid;
    logic                 r_out_seq_valid;
    logic [SW-1:0]        r_out_seq;

    logic [FW-1:0]        r_newest_frame;
    logic                 r_newest_dropped;
    logic [SW-1:0]        r_first_seq;
    logic [SW-1:0]        r_last_seq;
    logic                 r_end_seen;
    logic [SW-1:0]        r_removed;
    logic [FW-1:0]        r_highest_dropped;

    logic [FW-1:0]        n_newest_frame;
    logic                 n_newest_dropped;
    logic [SW-1:0]        n_first_seq;
    logic [SW-1:0]        n_last_seq;
    logic                 n_end_seen;
    logic [SW-1:0]        n_removed;
    logic [FW-1:0]        n_highest_dropped;
    logic                 n_seq_valid;
    logic [SW-1:0]        n_seq;

    logic                 advance;
    rtpsr_pkg::t_mark     mark;
    logic [FW:0]          frame_x;
    logic [FW:0]          newest_x;
    logic [FW:0]          newest_p1;
    logic [FW:0]          skip_gap;
    logic [SW-1:0]        seq_m1;
    logic [SW-1:0]        seq_p1;
    logic [SW-1:0]        span;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_seq_valid      = r_out_seq_valid;
    assign o_new_seq_number = r_out_seq;

    always_comb begin
        if (r_in_eof) begin
            mark = rtpsr_pkg::MARK_END;
        end else if (r_in_sof) begin
            mark = rtpsr_pkg::MARK_START;
        end else begin
            mark = rtpsr_pkg::MARK_INTER;
        end
    end

    assign frame_x   = {1'b0, r_in_frame};
    assign newest_x  = {1'b0, r_newest_frame};
    assign newest_p1 = newest_x + {{FW{1'b0}}, 1'b1};
    assign skip_gap  = frame_x - newest_x + {{FW{1'b0}}, 1'b1};
    assign seq_m1    = r_in_seq - {{(SW-1){1'b0}}, 1'b1};
    assign seq_p1    = r_in_seq + {{(SW-1){1'b0}}, 1'b1};
    assign span      = r_last_seq - r_first_seq + {{(SW-1){1'b0}}, 1'b1};

    always_comb begin
        n_newest_frame    = r_newest_frame;
        n_newest_dropped  = r_newest_dropped;
        n_first_seq       = r_first_seq;
        n_last_seq        = r_last_seq;
        n_end_seen        = r_end_seen;
        n_removed         = r_removed;
        n_highest_dropped = r_highest_dropped;
        n_seq_valid       = 1'b0;
        n_seq             = '0;

        if (r_in_frame > 16'd1 && r_newest_frame == '0) begin
            n_newest_frame   = r_in_frame;
            n_newest_dropped = r_in_drop;
            n_first_seq      = (mark == rtpsr_pkg::MARK_START) ? r_in_seq : seq_m1;
            n_last_seq       = (mark == rtpsr_pkg::MARK_END) ? r_in_seq : seq_p1;
            if (!r_in_drop) begin
                n_seq_valid = 1'b1;
                n_seq       = r_in_seq;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                n_removed = rtpsr_pkg::EDGE_REMOVE;
            end
            if (mark == rtpsr_pkg::MARK_END) begin
                n_end_seen = 1'b1;
            end
        end else if (frame_x == newest_x) begin
            if (mark == rtpsr_pkg::MARK_START) begin
                n_first_seq = r_in_seq;
            end else if (r_in_seq == r_first_seq) begin
                n_first_seq = seq_m1;
            end
            if (mark == rtpsr_pkg::MARK_END) begin
                n_last_seq = r_in_seq;
            end else if (!r_end_seen) begin
                n_last_seq = seq_p1;
            end
            if (!r_in_drop) begin
                n_seq_valid = 1'b1;
                n_seq       = r_in_seq - r_removed;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                n_removed = r_removed + r_in_seq - n_first_seq
                          + {{(SW-1){1'b0}}, 1'b1};
            end
            if (mark == rtpsr_pkg::MARK_END) begin
                n_end_seen = 1'b1;
            end
        end else if (frame_x == newest_p1) begin
            n_newest_frame = r_in_frame;
            if (r_newest_dropped && !r_end_seen) begin
                n_removed = r_removed + ((mark == rtpsr_pkg::MARK_START)
                          ? (r_in_seq - r_first_seq) : rtpsr_pkg::NEXT_GAP_REMOVE);
            end else if (r_in_drop && mark == rtpsr_pkg::MARK_END) begin
                n_removed = r_removed + (r_end_seen
                          ? (r_in_seq - r_last_seq) : rtpsr_pkg::EDGE_REMOVE);
            end
            n_newest_dropped = r_in_drop;
            n_first_seq      = (mark == rtpsr_pkg::MARK_START) ? r_in_seq : seq_m1;
            n_last_seq       = (mark == rtpsr_pkg::MARK_END) ? r_in_seq : seq_p1;
            if (!r_in_drop) begin
                n_seq_valid = 1'b1;
                n_seq       = r_in_seq - n_removed;
            end
            n_end_seen = (mark == rtpsr_pkg::MARK_END);
        end else if (frame_x > newest_p1) begin
            if (!r_newest_dropped && !r_in_drop &&
                skip_gap >= {1'b0, r_skip_threshold}) begin
                n_removed = n_removed + rtpsr_pkg::EDGE_REMOVE;
            end
            n_newest_frame = r_in_frame;
            if (r_newest_dropped && !r_end_seen) begin
                n_removed = n_removed + r_last_seq - r_first_seq;
            end
            n_newest_dropped = r_in_drop;
            if (mark == rtpsr_pkg::MARK_START) begin
                n_first_seq = r_in_seq;
            end else if (r_in_seq == r_first_seq) begin
                n_first_seq = seq_m1;
            end else if (mark == rtpsr_pkg::MARK_INTER) begin
                n_first_seq = seq_m1;
            end else begin
                n_first_seq = r_in_seq - rtpsr_pkg::EDGE_REMOVE;
            end
            n_last_seq = (mark == rtpsr_pkg::MARK_END) ? r_in_seq : seq_p1;
            if (!r_in_drop) begin
                n_seq_valid = 1'b1;
                n_seq       = r_in_seq - n_removed;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                n_removed = n_removed + rtpsr_pkg::EDGE_REMOVE;
            end
            n_end_seen = (mark == rtpsr_pkg::MARK_END);
        end else begin
            if (r_in_drop) begin
                n_seq_valid = 1'b0;
            end else if (frame_x + {{FW{1'b0}}, 1'b1} == newest_x) begin
                n_seq_valid = 1'b1;
                if (!r_newest_dropped || !r_end_seen) begin
                    n_seq = r_in_seq - r_removed;
                end else begin
                    n_seq = r_in_seq - (r_removed - span);
                end
            end else if (r_in_frame > r_highest_dropped || !r_drop_when_unsure) begin
                n_seq_valid = 1'b1;
                n_seq       = r_in_seq - r_removed;
            end
        end

        if (r_in_drop && r_in_frame > r_highest_dropped) begin
            n_highest_dropped = r_in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_when_unsure <= 1'b0;
            r_skip_threshold   <= rtpsr_pkg::SKIP_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtpsr_pkg::CFG_DROP_WHEN_UNSURE: r_drop_when_unsure <= i_cfg_data[0];
                rtpsr_pkg::CFG_SKIP_THRESHOLD:   r_skip_threshold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_frame <= i_frame_number;
            r_in_seq   <= i_seq_number;
            r_in_sof   <= i_start_of_frame;
            r_in_eof   <= i_end_of_frame;
            r_in_drop  <= i_drop_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_seq_valid <= n_seq_valid;
            r_out_seq       <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest_frame    <= '0;
            r_newest_dropped  <= 1'b0;
            r_first_seq       <= '0;
            r_last_seq        <= '0;
            r_end_seen        <= 1'b0;
            r_removed         <= '0;
            r_highest_dropped <= '0;
        end else if (advance) begin
            r_newest_frame    <= n_newest_frame;
            r_newest_dropped  <= n_newest_dropped;
            r_first_seq       <= n_first_seq;
            r_last_seq        <= n_last_seq;
            r_end_seen        <= n_end_seen;
            r_removed         <= n_removed;
            r_highest_dropped <= n_highest_dropped;
        end
    end

    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_seq_valid) |-> (o_new_seq_number == '0))
        else $error("suppressed result carries a nonzero sequence number");

    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed request produced no result");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    a_newest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_newest_frame >= $past(r_newest_frame)))
        else $error("newest frame moved backward");

    a_highest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_highest_dropped >= $past(r_highest_dropped)))
        else $error("highest dropped frame moved backward");

endmodule

### sim/tb_rtp_sequence_rewriter_on_frame_drop_top.sv
`timescale 1ns / 1ps
// Testbench for rtp_sequence_rewriter_on_frame_drop_top: directed rows around random packet
// streams under changing idle patterns; results are checked against a local predictor, or
// against the row's own value where known. Depends on rtpsr_pkg and the top module only.
module tb_rtp_sequence_rewriter_on_frame_drop_top;

    localparam int SEQ_W      = rtpsr_pkg::SEQ_W;
    localparam int FRAME_W    = rtpsr_pkg::FRAME_W;
    localparam int CFG_IDX_W  = rtpsr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rtpsr_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [SEQ_W-1:0]   seq;
        logic               sof;
        logic               eof;
        logic               drop;
    } t_pkt;

    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
    } t_seq_out;

    typedef struct packed {
        t_pkt             pkt;
        logic             known;
        logic             exp_valid;
        logic [SEQ_W-1:0] exp_seq;
    } t_dir_row;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam int HEAD_ROWS = 14;
    localparam int DIR_ROWS_N = 21;
    localparam logic [FRAME_W-1:0] FRAME_CAP = 16'd65000;

    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{'{16'd0,     16'd0,     1'b1, 1'b0, 1'b0}, 1'b1, 1'b1, 16'd0},
        '{'{16'd0,     16'd65535, 1'b0, 1'b0, 1'b0}, 1'b1, 1'b1, 16'd65535},
        '{'{16'd4,     16'd10,    1'b0, 1'b1, 1'b1}, 1'b1, 1'b0, 16'd0},
        '{'{16'd5,     16'd11,    1'b1, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd5,     16'd12,    1'b0, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0},
        '{'{16'd5,     16'd13,    1'b1, 1'b1, 1'b1}, 1'b1, 1'b0, 16'd0},
        '{'{16'd6,     16'd14,    1'b0, 1'b0, 1'b1}, 1'b0, 1'b0, 16'd0},
        '{'{16'd7,     16'd20,    1'b1, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd12,    16'd30,    1'b0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd12,    16'd31,    1'b0, 1'b0, 1'b1}, 1'b0, 1'b0, 16'd0},
        '{'{16'd20,    16'd40,    1'b0, 1'b1, 1'b1}, 1'b0, 1'b0, 16'd0},
        '{'{16'd11,    16'd50,    1'b0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd19,    16'd51,    1'b0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd3,     16'd52,    1'b1, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0},
        '{'{16'd65535, 16'd65535, 1'b1, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd65535, 16'd0,     1'b0, 1'b1, 1'b1}, 1'b0, 1'b0, 16'd0},
        '{'{16'd65534, 16'd1,     1'b0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd0,     16'd2,     1'b1, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0},
        '{'{16'd65535, 16'd65535, 1'b1, 1'b1, 1'b1}, 1'b0, 1'b0, 16'd0},
        '{'{16'd0,     16'd3,     1'b0, 1'b0, 1'b1}, 1'b1, 1'b0, 16'd0},
        '{'{16'd65535, 16'd4,     1'b0, 1'b0, 1'b0}, 1'b0, 1'b0, 16'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [FRAME_W-1:0]    i_frame_number;
    logic [SEQ_W-1:0]      i_seq_number;
    logic                  i_start_of_frame;
    logic                  i_end_of_frame;
    logic                  i_drop_packet;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_seq_valid;
    logic [SEQ_W-1:0]      o_new_seq_number;

    rtp_sequence_rewriter_on_frame_drop_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_number   (i_frame_number),
        .i_seq_number     (i_seq_number),
        .i_start_of_frame (i_start_of_frame),
        .i_end_of_frame   (i_end_of_frame),
        .i_drop_packet    (i_drop_packet),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_seq_valid      (o_seq_valid),
        .o_new_seq_number (o_new_seq_number)
    );

    logic             cfg_unsure;
    logic [SEQ_W-1:0] cfg_cadence;
    logic [FRAME_W-1:0] head_frame;
    logic             head_dropped;
    logic [SEQ_W-1:0] head_first_seq;
    logic [SEQ_W-1:0] head_last_seq;
    logic             head_end_seen;
    logic [SEQ_W-1:0] removed_seqs;
    logic [FRAME_W-1:0] top_dropped_frame;

    t_seq_out expected_seqs [$];
    logic     row_known;
    t_seq_out row_want;
    int       fail_count;
    int       send_idle;
    int       recv_idle;
    int       recv_hold;
    logic [FRAME_W-1:0] stream_frame;
    logic [SEQ_W-1:0]   stream_seq;

    function automatic t_seq_out rewrite_seq(input t_pkt p);
        t_seq_out r;
        rtpsr_pkg::t_mark mark;
        int fr;
        int nw;
        logic [SEQ_W-1:0] span;
        r.valid = 1'b0;
        r.seq = '0;
        mark = p.eof ? rtpsr_pkg::MARK_END
                     : (p.sof ? rtpsr_pkg::MARK_START : rtpsr_pkg::MARK_INTER);
        fr = int'(p.frame);
        nw = int'(head_frame);
        if (fr > 1 && nw == 0) begin
            head_frame = p.frame;
            head_dropped = p.drop;
            head_first_seq = (mark == rtpsr_pkg::MARK_START) ? p.seq : p.seq - 16'd1;
            head_last_seq = (mark == rtpsr_pkg::MARK_END) ? p.seq : p.seq + 16'd1;
            if (!p.drop) begin
                r.valid = 1'b1;
                r.seq = p.seq;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                removed_seqs = rtpsr_pkg::EDGE_REMOVE;
            end
            if (mark == rtpsr_pkg::MARK_END) head_end_seen = 1'b1;
        end else if (fr == nw) begin
            if (mark == rtpsr_pkg::MARK_START) head_first_seq = p.seq;
            else if (p.seq == head_first_seq) head_first_seq = p.seq - 16'd1;
            if (mark == rtpsr_pkg::MARK_END) head_last_seq = p.seq;
            else if (!head_end_seen) head_last_seq = p.seq + 16'd1;
            if (!p.drop) begin
                r.valid = 1'b1;
                r.seq = p.seq - removed_seqs;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                removed_seqs = removed_seqs + p.seq - head_first_seq + 16'd1;
            end
            if (mark == rtpsr_pkg::MARK_END) head_end_seen = 1'b1;
        end else if (fr == nw + 1) begin
            head_frame = p.frame;
            if (head_dropped && !head_end_seen) begin
                removed_seqs = removed_seqs + ((mark == rtpsr_pkg::MARK_START)
                    ? p.seq - head_first_seq : rtpsr_pkg::NEXT_GAP_REMOVE);
            end else if (p.drop && mark == rtpsr_pkg::MARK_END) begin
                removed_seqs = removed_seqs +
                    (head_end_seen ? p.seq - head_last_seq : rtpsr_pkg::EDGE_REMOVE);
            end
            head_dropped = p.drop;
            head_first_seq = (mark == rtpsr_pkg::MARK_START) ? p.seq : p.seq - 16'd1;
            head_last_seq = (mark == rtpsr_pkg::MARK_END) ? p.seq : p.seq + 16'd1;
            if (!p.drop) begin
                r.valid = 1'b1;
                r.seq = p.seq - removed_seqs;
            end
            head_end_seen = (mark == rtpsr_pkg::MARK_END);
        end else if (fr > nw + 1) begin
            if (!head_dropped && !p.drop && (fr - nw + 1) >= int'(cfg_cadence))
                removed_seqs = removed_seqs + rtpsr_pkg::EDGE_REMOVE;
            head_frame = p.frame;
            if (head_dropped && !head_end_seen)
                removed_seqs = removed_seqs + head_last_seq - head_first_seq;
            head_dropped = p.drop;
            if (mark == rtpsr_pkg::MARK_START) head_first_seq = p.seq;
            else if (p.seq == head_first_seq) head_first_seq = p.seq - 16'd1;
            else if (mark == rtpsr_pkg::MARK_INTER) head_first_seq = p.seq - 16'd1;
            else head_first_seq = p.seq - rtpsr_pkg::EDGE_REMOVE;
            head_last_seq = (mark == rtpsr_pkg::MARK_END) ? p.seq : p.seq + 16'd1;
            if (!p.drop) begin
                r.valid = 1'b1;
                r.seq = p.seq - removed_seqs;
            end else if (mark == rtpsr_pkg::MARK_END) begin
                removed_seqs = removed_seqs + rtpsr_pkg::EDGE_REMOVE;
            end
            head_end_seen = (mark == rtpsr_pkg::MARK_END);
        end else begin
            if (p.drop) begin
                r.valid = 1'b0;
            end else if (fr + 1 == nw) begin
                r.valid = 1'b1;
                if (!head_dropped || !head_end_seen) begin
                    r.seq = p.seq - removed_seqs;
                end else begin
                    span = head_last_seq - head_first_seq + 16'd1;
                    r.seq = p.seq - (removed_seqs - span);
                end
            end else if (p.frame > top_dropped_frame || !cfg_unsure) begin
                r.valid = 1'b1;
                r.seq = p.seq - removed_seqs;
            end
        end
        if (p.drop && p.frame > top_dropped_frame) top_dropped_frame = p.frame;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pkt     p;
        t_seq_out want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rtpsr_pkg::CFG_DROP_WHEN_UNSURE: cfg_unsure = i_cfg_data[0];
                    rtpsr_pkg::CFG_SKIP_THRESHOLD:   cfg_cadence = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                p = '{i_frame_number, i_seq_number, i_start_of_frame, i_end_of_frame,
                      i_drop_packet};
                want = rewrite_seq(p);
                if (row_known) want = row_want;
                expected_seqs.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_seqs.size() == 0) begin
                    $error("unexpected result: seq_valid %0d new_seq_number %0d",
                           o_seq_valid, o_new_seq_number);
                    fail_count++;
                end else begin
                    want = expected_seqs.pop_front();
                    if (o_seq_valid !== want.valid) begin
                        $error("seq_valid: expected %0d, got %0d", want.valid, o_seq_valid);
                        fail_count++;
                    end
                    if (o_new_seq_number !== want.seq) begin
                        $error("new_seq_number: expected %0d, got %0d",
                               want.seq, o_new_seq_number);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (int'($urandom_range(99)) >= recv_idle);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_packet(input t_pkt p, input logic known, input t_seq_out want);
        while (int'($urandom_range(99)) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        row_known = known;
        row_want = want;
        i_in_valid <= 1'b1;
        i_frame_number <= p.frame;
        i_seq_number <= p.seq;
        i_start_of_frame <= p.sof;
        i_end_of_frame <= p.eof;
        i_drop_packet <= p.drop;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic run_rows(input int lo, input int hi);
        t_seq_out want;
        for (int k = lo; k <= hi; k++) begin
            want.valid = DIR_ROWS[k].exp_valid;
            want.seq = DIR_ROWS[k].exp_seq;
            send_packet(DIR_ROWS[k].pkt, DIR_ROWS[k].known, want);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_seqs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic cfg_phase(input logic unsure, input logic [SEQ_W-1:0] cadence);
        drain();
        write_reg(rtpsr_pkg::CFG_DROP_WHEN_UNSURE, {15'($urandom), unsure});
        write_reg(rtpsr_pkg::CFG_SKIP_THRESHOLD, cadence);
        write_reg(CFG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_stream(input int n);
        int sent;
        int len;
        int lo;
        int hi;
        int mode;
        int cut;
        int gap;
        int r;
        t_pkt p;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                len = $urandom_range(1, 5);
                mode = $urandom_range(9);
                cut = $urandom_range(0, len - 1);
                lo = ($urandom_range(9) == 0) ? 1 : 0;
                hi = ($urandom_range(9) == 0) ? len - 2 : len - 1;
                for (int i = lo; i <= hi; i++) begin
                    p.frame = stream_frame;
                    p.seq = stream_seq + 16'(i);
                    p.sof = (i == 0);
                    p.eof = (i == len - 1);
                    p.drop = (mode < 3) || (mode == 3 && i >= cut) ||
                             (mode == 4 && $urandom_range(1) == 1);
                    send_packet(p, 1'b0, '0);
                    sent++;
                end
                stream_seq = stream_seq + 16'(len) + 16'($urandom_range(0, 2));
                r = $urandom_range(99);
                gap = (r < 70) ? 1 : (r < 90) ? $urandom_range(2, 6) :
                      (r < 96) ? $urandom_range(7, 40) : $urandom_range(1000, 12000);
                if (int'(stream_frame) + gap <= int'(FRAME_CAP))
                    stream_frame = stream_frame + 16'(gap);
            end else begin
                if (r < 88) begin
                    p.frame = ($urandom_range(1) == 1) ? stream_frame - 16'($urandom_range(1,
                              (stream_frame > 16'd4) ? 4 : int'(stream_frame))) :
                              16'($urandom_range(0, int'(stream_frame)));
                    p.seq = stream_seq - 16'($urandom_range(1, 40));
                end else begin
                    p.frame = 16'($urandom_range(0, int'(stream_frame)));
                    p.seq = 16'($urandom);
                end
                p.sof = 1'($urandom_range(1));
                p.eof = 1'($urandom_range(1));
                p.drop = 1'($urandom_range(1));
                send_packet(p, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_frame_number = '0;
        i_seq_number = '0;
        i_start_of_frame = 1'b0;
        i_end_of_frame = 1'b0;
        i_drop_packet = 1'b0;
        row_known = 1'b0;
        row_want = '0;
        fail_count = 0;
        send_idle = 0;
        recv_idle = 0;
        recv_hold = 0;
        cfg_unsure = 1'b0;
        cfg_cadence = rtpsr_pkg::SKIP_THRESHOLD_RESET;
        head_frame = '0;
        head_dropped = 1'b0;
        head_first_seq = '0;
        head_last_seq = '0;
        head_end_seen = 1'b0;
        removed_seqs = '0;
        top_dropped_frame = '0;
        stream_seq = 16'($urandom);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_rows(0, HEAD_ROWS - 1);

        cfg_phase(1'b1, 16'd0);
        send_idle = 19;
        recv_idle = 49;
        stream_frame = head_frame + 16'd1;
        send_stream(130);

        cfg_phase(1'b0, 16'hFFFF);
        send_idle = 49;
        recv_idle = 19;
        recv_hold = 300;
        stream_frame = head_frame + 16'd1;
        send_stream(130);

        cfg_phase(1'b1, 16'($urandom_range(1, 6)));
        send_idle = 0;
        recv_idle = 0;
        stream_frame = (head_frame < 16'd33000) ? 16'd33000 : head_frame + 16'd1;
        send_stream(70);
        drain();
        send_stream(70);

        run_rows(HEAD_ROWS, DIR_ROWS_N - 1);
        drain();
        repeat (10) @(negedge i_clk);

        if (fail_count == 0 && expected_seqs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
sv/rtpsr_pkg.sv
sv/rtp_sequence_rewriter_on_frame_drop_top.sv
sim/tb_rtp_sequence_rewriter_on_frame_drop_top.sv
